// ----- rtl/rotor_flight_mode_supervisor_defines.svh -----
// Assertion macros used by the checker file.
`ifndef ROTOR_FLIGHT_MODE_SUPERVISOR_DEFINES_SVH
`define ROTOR_FLIGHT_MODE_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RFMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RFMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rfms_pkg.sv -----
package rfms_pkg;

  // flight modes
  localparam logic [2:0] MODE_OFF         = 3'd0;
  localparam logic [2:0] MODE_IDLE        = 3'd1;
  localparam logic [2:0] MODE_ENGAGING    = 3'd2;
  localparam logic [2:0] MODE_DISENGAGING = 3'd3;
  localparam logic [2:0] MODE_FLYING      = 3'd4;
  localparam logic [2:0] MODE_LANDING     = 3'd5;
  localparam logic [2:0] MODE_ERROR       = 3'd6;

  // action codes
  localparam logic [2:0] ACT_TOGGLE  = 3'd0;
  localparam logic [2:0] ACT_ESTOP   = 3'd1;
  localparam logic [2:0] ACT_TAKEOFF = 3'd2;
  localparam logic [2:0] ACT_LAND    = 3'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_AXIS_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_LAND_STEP   = 2'd2;

  localparam logic [23:0] TIMEOUT_RESET   = 24'd2000000;
  localparam logic [11:0] LAND_STEP_RESET = 12'd1;

  // landing ramp period in ticks
  localparam int LAND_PERIOD = 100;
  localparam int LAND_CW     = $clog2(LAND_PERIOD + 1);
  localparam logic [LAND_CW-1:0] LAND_LAST = LAND_CW'(LAND_PERIOD - 1);

  // beeper pattern points
  localparam logic [6:0] FAST_LAST  = 7'd99;
  localparam logic [6:0] FAST_ON    = 7'd0;
  localparam logic [6:0] FAST_OFF   = 7'd50;
  localparam logic [9:0] SLOW_LAST  = 10'd999;
  localparam logic [9:0] SLOW_ON_A  = 10'd0;
  localparam logic [9:0] SLOW_ON_B  = 10'd100;
  localparam logic [9:0] SLOW_OFF_A = 10'd50;
  localparam logic [9:0] SLOW_OFF_B = 10'd150;

  localparam logic signed [11:0] YAW_TOGGLE = 12'sd2047;
  localparam logic [3:0] MASK_TOGGLE  = 4'hC;
  localparam logic [3:0] MASK_LANDING = 4'h8;
  localparam logic [3:0] MASK_ALL     = 4'hF;

  typedef struct packed {
    logic [3:0]  axis_enable;
    logic [23:0] timeout_us;
    logic [11:0] land_step;
  } cfg_t;

  typedef struct packed {
    logic               motors_on;
    logic               serial_enabled;
    logic               action_valid;
    logic [2:0]         action;
    logic [62:0]        now_us;
    logic signed [11:0] ctrl_roll;
    logic signed [11:0] ctrl_pitch;
    logic signed [11:0] ctrl_yaw_rate;
    logic [11:0]        ctrl_thrust;
  } item_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               motors_were_running;
    logic [62:0]        toggle_start;
    logic [31:0]        tick;
    logic [6:0]         tick_fast;
    logic [9:0]         tick_slow;
    logic [LAND_CW-1:0] tick_land;
    logic [11:0]        landing_thrust;
    logic               beeper;
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               drive_enable;
    logic [3:0]         axis_mask;
    logic signed [11:0] roll;
    logic signed [11:0] pitch;
    logic signed [11:0] yaw;
    logic [11:0]        thrust;
    logic               beeper_on;
    logic               controller_reset;
  } result_t;

endpackage

// ----- rtl/rotor_flight_mode_supervisor.sv -----
// Flight mode supervisor: one input word is one control tick, and one result word
// comes out for every tick, in order. The block takes a tick in every cycle while
// the result side keeps up; a tick is held in the input register, evaluated against
// the mode state in one pass of logic and written with the new state into the result
// register, from which the result is presented. While a finished result waits, the
// input register takes one more tick and then holds off until the result is taken.
// The beeper pattern and the landing period run off residue counters that follow
// the 32-bit tick count, wrap included. Configuration writes take effect for
// ticks evaluated after the write; write only while no tick is in flight.
module rotor_flight_mode_supervisor
  import rfms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_motors_on,
  input  logic               in_serial_enabled,
  input  logic               in_action_valid,
  input  logic [2:0]         in_action,
  input  logic [62:0]        in_now_us,
  input  logic signed [11:0] in_ctrl_roll,
  input  logic signed [11:0] in_ctrl_pitch,
  input  logic signed [11:0] in_ctrl_yaw_rate,
  input  logic [11:0]        in_ctrl_thrust,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_mode,
  output logic               out_drive_enable,
  output logic [3:0]         out_axis_mask,
  output logic signed [11:0] out_roll_out,
  output logic signed [11:0] out_pitch_out,
  output logic signed [11:0] out_yaw_out,
  output logic [11:0]        out_thrust_out,
  output logic               out_beeper_on,
  output logic               out_controller_reset,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  logic    s1_valid_r;
  item_t   item_r;
  state_t  st_r;
  state_t  st_nxt;
  cfg_t    cfg_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;
  logic    advance;
  logic    in_fire;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  rfms_step u_step (
    .st     (st_r),
    .item   (item_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      st_r              <= '0;
      cfg_r.axis_enable <= 4'd0;
      cfg_r.timeout_us  <= TIMEOUT_RESET;
      cfg_r.land_step   <= LAND_STEP_RESET;
    end else begin
      if (in_fire) s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;

      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (advance) st_r <= st_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_AXIS_ENABLE: cfg_r.axis_enable <= cfg_wdata[3:0];
          CFG_TIMEOUT:     cfg_r.timeout_us  <= cfg_wdata;
          CFG_LAND_STEP:   cfg_r.land_step   <= cfg_wdata[11:0];
          default: ;
        endcase
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.motors_on      <= in_motors_on;
      item_r.serial_enabled <= in_serial_enabled;
      item_r.action_valid   <= in_action_valid;
      item_r.action         <= in_action;
      item_r.now_us         <= in_now_us;
      item_r.ctrl_roll      <= in_ctrl_roll;
      item_r.ctrl_pitch     <= in_ctrl_pitch;
      item_r.ctrl_yaw_rate  <= in_ctrl_yaw_rate;
      item_r.ctrl_thrust    <= in_ctrl_thrust;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_mode             = res_r.mode;
  assign out_drive_enable     = res_r.drive_enable;
  assign out_axis_mask        = res_r.axis_mask;
  assign out_roll_out         = res_r.roll;
  assign out_pitch_out        = res_r.pitch;
  assign out_yaw_out          = res_r.yaw;
  assign out_thrust_out       = res_r.thrust;
  assign out_beeper_on        = res_r.beeper_on;
  assign out_controller_reset = res_r.controller_reset;

endmodule

// ----- rtl/rfms_step.sv -----
module rfms_step
  import rfms_pkg::*;
(
  input  state_t  st,
  input  item_t   item,
  input  cfg_t    cfg,
  output state_t  st_nxt,
  output result_t res
);

  logic [31:0] tick_n;
  logic        wrap;
  logic [2:0]  mode;
  logic        act;
  logic [63:0] diff;

  always_comb begin
    st_nxt = st;
    res    = '0;

    tick_n = st.tick + 32'd1;
    wrap   = (tick_n == 32'd0);
    st_nxt.tick      = tick_n;
    // residues restart on counter wrap, since the wrapped count is zero
    st_nxt.tick_fast = (wrap || st.tick_fast == FAST_LAST) ? 7'd0 : st.tick_fast + 7'd1;
    st_nxt.tick_slow = (wrap || st.tick_slow == SLOW_LAST) ? 10'd0 : st.tick_slow + 10'd1;
    st_nxt.tick_land = (wrap || st.tick_land == LAND_LAST) ? '0
                     : st.tick_land + LAND_CW'(1);

    // beeper pattern from the mode held at the start of the tick
    if (st.mode == MODE_ERROR) begin
      if (st_nxt.tick_fast == FAST_ON) st_nxt.beeper = 1'b1;
      if (st_nxt.tick_fast == FAST_OFF) st_nxt.beeper = 1'b0;
    end else if (item.serial_enabled) begin
      if (st_nxt.tick_slow == SLOW_ON_A || st_nxt.tick_slow == SLOW_ON_B)
        st_nxt.beeper = 1'b1;
      if (st_nxt.tick_slow == SLOW_OFF_A || st_nxt.tick_slow == SLOW_OFF_B)
        st_nxt.beeper = 1'b0;
    end else begin
      if (st_nxt.tick_slow == SLOW_ON_A) st_nxt.beeper = 1'b1;
      if (st_nxt.tick_slow == SLOW_OFF_A) st_nxt.beeper = 1'b0;
    end

    mode = st.mode;
    if (!st.motors_were_running && item.motors_on) begin
      mode = MODE_IDLE;
    end else if (st.motors_were_running && !item.motors_on) begin
      if (mode != MODE_ERROR) mode = MODE_OFF;
    end
    st_nxt.motors_were_running = item.motors_on;

    act = item.action_valid && item.serial_enabled;
    if (act) begin
      case (item.action)
        ACT_TOGGLE: begin
          if (mode == MODE_OFF) begin
            mode = MODE_ENGAGING;
            st_nxt.toggle_start = item.now_us;
          end else if (mode == MODE_IDLE) begin
            mode = MODE_DISENGAGING;
            st_nxt.toggle_start = item.now_us;
          end
        end
        ACT_ESTOP: mode = MODE_ERROR;
        ACT_TAKEOFF: begin
          if (mode == MODE_IDLE) begin
            mode = MODE_FLYING;
            res.controller_reset = 1'b1;
          end
        end
        ACT_LAND: begin
          if (mode == MODE_FLYING) begin
            mode = MODE_LANDING;
            st_nxt.landing_thrust = item.ctrl_thrust;
          end
        end
        default: ;
      endcase
    end

    // signed elapsed time; a timestamp that went backwards never trips
    diff = {1'b0, item.now_us} - {1'b0, st_nxt.toggle_start};
    if ((mode == MODE_ENGAGING || mode == MODE_DISENGAGING) &&
        $signed(diff) >= $signed({40'd0, cfg.timeout_us}))
      mode = MODE_ERROR;

    if (mode == MODE_LANDING) begin
      if (st_nxt.landing_thrust != 12'd0) begin
        if (st_nxt.tick_land == '0) begin
          if (st_nxt.landing_thrust > cfg.land_step)
            st_nxt.landing_thrust = st_nxt.landing_thrust - cfg.land_step;
          else
            st_nxt.landing_thrust = 12'd0;
        end
      end else begin
        mode = MODE_IDLE;
      end
    end
    st_nxt.mode = mode;

    res.mode         = mode;
    res.drive_enable = 1'b1;
    res.beeper_on    = st_nxt.beeper;
    case (mode)
      MODE_ERROR: res.drive_enable = 1'b0;
      MODE_ENGAGING, MODE_DISENGAGING: begin
        res.axis_mask = MASK_TOGGLE;
        res.yaw       = YAW_TOGGLE;
      end
      MODE_LANDING: begin
        res.axis_mask = MASK_LANDING;
        res.thrust    = st_nxt.landing_thrust;
      end
      MODE_FLYING: begin
        res.axis_mask = cfg.axis_enable;
        res.roll      = item.ctrl_roll;
        res.pitch     = item.ctrl_pitch;
        res.yaw       = item.ctrl_yaw_rate;
        res.thrust    = item.ctrl_thrust;
      end
      default: res.axis_mask = MASK_ALL;
    endcase
  end

endmodule

// ----- rtl/rfms_checker.sv -----
`include "rotor_flight_mode_supervisor_defines.svh"

module rfms_checker
  import rfms_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_mode,
  input logic               out_drive_enable,
  input logic signed [11:0] out_roll_out,
  input logic signed [11:0] out_pitch_out,
  input logic [11:0]        out_thrust_out,
  input logic               out_controller_reset
);

  // drive is cut exactly in error
  `RFMS_ASSERT_NOW(a_drive_vs_error, out_valid, out_drive_enable == (out_mode != MODE_ERROR), "drive_enable does not match error mode")

  // the controller reset pulse only comes with a takeoff into flying
  `RFMS_ASSERT_NOW(a_reset_flying, out_valid && out_controller_reset, out_mode == MODE_FLYING, "controller reset outside flying")

  // roll and pitch pass through only while flying
  `RFMS_ASSERT_NOW(a_attitude_zero, out_valid && out_mode != MODE_FLYING, out_roll_out == 12'sd0 && out_pitch_out == 12'sd0, "attitude command outside flying")

  // a stalled result word holds
  `RFMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mode) && $stable(out_thrust_out), "stalled result changed")

endmodule

bind rotor_flight_mode_supervisor rfms_checker u_rfms_checker (.*);

// ----- test/rotor_flight_mode_supervisor_test.sv -----
`timescale 1ns / 1ps

module rotor_flight_mode_supervisor_test;
  import rfms_pkg::*;

  localparam int RANDOM_TICKS  = 360;
  localparam int PHASES        = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LAND_TICK_CAP = 250;
  localparam int SHOWN_ERRORS  = 30;
  localparam logic [62:0] NOW_MAX = '1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  item_t tick_word;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_mode;
  logic out_drive_enable;
  logic [3:0] out_axis_mask;
  logic signed [11:0] out_roll_out;
  logic signed [11:0] out_pitch_out;
  logic signed [11:0] out_yaw_out;
  logic [11:0] out_thrust_out;
  logic out_beeper_on;
  logic out_controller_reset;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_wdata;

  // supervisor state as predicted from the accepted ticks
  logic [2:0] sv_mode;
  logic sv_motors_prev;
  logic [62:0] sv_toggle_start;
  logic [31:0] sv_tick;
  logic [11:0] sv_land_thrust;
  logic sv_beeper;
  logic [3:0] reg_axis_enable;
  logic [23:0] reg_timeout;
  logic [11:0] reg_land_step;

  result_t pending_results[$];
  logic [62:0] clock_us;
  bit steady = 1'b0;
  int ticks_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int landings_done = 0;
  int error_entries = 0;
  int cycle_count = 0;

  rotor_flight_mode_supervisor dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_motors_on(tick_word.motors_on),
    .in_serial_enabled(tick_word.serial_enabled),
    .in_action_valid(tick_word.action_valid),
    .in_action(tick_word.action),
    .in_now_us(tick_word.now_us),
    .in_ctrl_roll(tick_word.ctrl_roll),
    .in_ctrl_pitch(tick_word.ctrl_pitch),
    .in_ctrl_yaw_rate(tick_word.ctrl_yaw_rate),
    .in_ctrl_thrust(tick_word.ctrl_thrust),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mode(out_mode),
    .out_drive_enable(out_drive_enable),
    .out_axis_mask(out_axis_mask),
    .out_roll_out(out_roll_out),
    .out_pitch_out(out_pitch_out),
    .out_yaw_out(out_yaw_out),
    .out_thrust_out(out_thrust_out),
    .out_beeper_on(out_beeper_on),
    .out_controller_reset(out_controller_reset),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Advance the supervisor by one tick and return the word it should emit.
  function automatic result_t advance_supervisor(input item_t t);
    result_t r;
    logic signed [63:0] elapsed;
    logic [2:0] start_mode;
    int unsigned fast;
    int unsigned slow;
    r = '0;
    start_mode = sv_mode;
    sv_tick = sv_tick + 32'd1;
    fast = sv_tick % 100;
    slow = sv_tick % 1000;
    if (sv_mode == MODE_ERROR) begin
      if (fast == 0) sv_beeper = 1'b1;
      if (fast == 50) sv_beeper = 1'b0;
    end else if (t.serial_enabled) begin
      if (slow == 0 || slow == 100) sv_beeper = 1'b1;
      if (slow == 50 || slow == 150) sv_beeper = 1'b0;
    end else begin
      if (slow == 0) sv_beeper = 1'b1;
      if (slow == 50) sv_beeper = 1'b0;
    end

    if (!sv_motors_prev && t.motors_on) begin
      sv_mode = MODE_IDLE;
    end else if (sv_motors_prev && !t.motors_on && sv_mode != MODE_ERROR) begin
      sv_mode = MODE_OFF;
    end
    sv_motors_prev = t.motors_on;

    if (t.action_valid && t.serial_enabled) begin
      case (t.action)
        ACT_TOGGLE: begin
          if (sv_mode == MODE_OFF) begin
            sv_mode = MODE_ENGAGING;
            sv_toggle_start = t.now_us;
          end else if (sv_mode == MODE_IDLE) begin
            sv_mode = MODE_DISENGAGING;
            sv_toggle_start = t.now_us;
          end
        end
        ACT_ESTOP: sv_mode = MODE_ERROR;
        ACT_TAKEOFF: begin
          if (sv_mode == MODE_IDLE) begin
            sv_mode = MODE_FLYING;
            r.controller_reset = 1'b1;
          end
        end
        ACT_LAND: begin
          if (sv_mode == MODE_FLYING) begin
            sv_mode = MODE_LANDING;
            sv_land_thrust = t.ctrl_thrust;
          end
        end
        default: ;
      endcase
    end

    // a timestamp behind the toggle start gives a negative difference
    if (sv_mode == MODE_ENGAGING || sv_mode == MODE_DISENGAGING) begin
      elapsed = $signed({1'b0, t.now_us}) - $signed({1'b0, sv_toggle_start});
      if (elapsed >= $signed({40'd0, reg_timeout})) sv_mode = MODE_ERROR;
    end

    if (sv_mode == MODE_LANDING) begin
      if (sv_land_thrust != 12'd0) begin
        if (sv_tick % LAND_PERIOD == 0) begin
          sv_land_thrust = (sv_land_thrust > reg_land_step) ?
                           sv_land_thrust - reg_land_step : 12'd0;
        end
      end else begin
        sv_mode = MODE_IDLE;
        landings_done++;
      end
    end
    if (sv_mode == MODE_ERROR && start_mode != MODE_ERROR) error_entries++;

    r.mode = sv_mode;
    r.drive_enable = 1'b1;
    r.beeper_on = sv_beeper;
    case (sv_mode)
      MODE_ERROR: r.drive_enable = 1'b0;
      MODE_ENGAGING, MODE_DISENGAGING: begin
        r.axis_mask = MASK_TOGGLE;
        r.yaw = YAW_TOGGLE;
      end
      MODE_LANDING: begin
        r.axis_mask = MASK_LANDING;
        r.thrust = sv_land_thrust;
      end
      MODE_FLYING: begin
        r.axis_mask = reg_axis_enable;
        r.roll = t.ctrl_roll;
        r.pitch = t.ctrl_pitch;
        r.yaw = t.ctrl_yaw_rate;
        r.thrust = t.ctrl_thrust;
      end
      default: r.axis_mask = MASK_ALL;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [11:0] got,
                                 input logic [11:0] want);
    if (mismatches < SHOWN_ERRORS) begin
      $display("mismatch on result %0d: %s got %h, want %h",
               results_checked, field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 12'd0, 12'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_mode !== want.mode)
          report_mismatch("mode", 12'(out_mode), 12'(want.mode));
        if (out_drive_enable !== want.drive_enable)
          report_mismatch("drive_enable", 12'(out_drive_enable), 12'(want.drive_enable));
        if (out_axis_mask !== want.axis_mask)
          report_mismatch("axis_mask", 12'(out_axis_mask), 12'(want.axis_mask));
        if (out_roll_out !== want.roll) report_mismatch("roll", out_roll_out, want.roll);
        if (out_pitch_out !== want.pitch) report_mismatch("pitch", out_pitch_out, want.pitch);
        if (out_yaw_out !== want.yaw) report_mismatch("yaw", out_yaw_out, want.yaw);
        if (out_thrust_out !== want.thrust)
          report_mismatch("thrust", out_thrust_out, want.thrust);
        if (out_beeper_on !== want.beeper_on)
          report_mismatch("beeper", 12'(out_beeper_on), 12'(want.beeper_on));
        if (out_controller_reset !== want.controller_reset)
          report_mismatch("controller_reset", 12'(out_controller_reset),
                          12'(want.controller_reset));
      end
      results_checked++;
    end
  end

  // result side backpressure
  always @(negedge clk) out_ready = steady || ($urandom_range(99) >= 8);

  task automatic send_tick(input item_t t);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 3) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_word = t;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_supervisor(t));
    ticks_sent++;
  endtask

  // Hold the input until every word in flight has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_AXIS_ENABLE: reg_axis_enable = value[3:0];
      CFG_TIMEOUT: reg_timeout = value;
      CFG_LAND_STEP: reg_land_step = value[11:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic item_t tick_of(input logic run, input logic serial, input logic valid,
                                    input logic [2:0] act, input logic [62:0] now,
                                    input logic [11:0] thrust);
    item_t t;
    t.motors_on = run;
    t.serial_enabled = serial;
    t.action_valid = valid;
    t.action = act;
    t.now_us = now;
    t.ctrl_roll = 12'($urandom);
    t.ctrl_pitch = 12'($urandom);
    t.ctrl_yaw_rate = 12'($urandom);
    t.ctrl_thrust = thrust;
    return t;
  endfunction

  // Advance the running timestamp, now and then backwards or far away.
  function automatic item_t make_tick(input logic run, input logic valid,
                                      input logic [2:0] act);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) clock_us = clock_us - 63'($urandom_range(1, 5000));
    else if (pick < 7) clock_us = 63'({$urandom, $urandom});
    else clock_us = clock_us + 63'($urandom_range(0, reg_timeout / 3 + 1));
    return tick_of(run, $urandom_range(99) < 93, valid, act, clock_us, 12'($urandom));
  endfunction

  task automatic test_directed_modes();
    item_t t;
    int code;
    t = tick_of(1'b0, 1'b1, 1'b0, ACT_TOGGLE, 63'd0, 12'd0);
    t.ctrl_roll = 12'h800;
    t.ctrl_pitch = 12'h800;
    t.ctrl_yaw_rate = 12'h800;
    send_tick(t);
    for (code = 4; code < 8; code++) begin
      send_tick(tick_of(1'b0, 1'b1, 1'b1, 3'(code), 63'd10, 12'hFFF));
    end
    send_tick(tick_of(1'b0, 1'b0, 1'b1, ACT_TOGGLE, 63'd20, 12'd0));
    send_tick(tick_of(1'b0, 1'b1, 1'b0, ACT_ESTOP, 63'd30, 12'd0));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, ACT_TAKEOFF, 63'd40, 12'd0));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, ACT_TOGGLE, NOW_MAX, 12'd0));
    // time jumps back to zero: must not time out
    send_tick(tick_of(1'b0, 1'b1, 1'b0, ACT_TOGGLE, 63'd0, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd1, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_LAND, 63'd2, 12'd0));
    t = tick_of(1'b1, 1'b1, 1'b1, ACT_TAKEOFF, 63'd3, 12'hFFF);
    t.ctrl_roll = 12'h7FF;
    t.ctrl_pitch = 12'h7FF;
    t.ctrl_yaw_rate = 12'h7FF;
    send_tick(t);
    t = tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd4, 12'd0);
    t.ctrl_roll = 12'h800;
    t.ctrl_pitch = 12'h800;
    t.ctrl_yaw_rate = 12'h800;
    send_tick(t);
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_TOGGLE, 63'd5, 12'd100));
    // land with zero thrust drops straight to idle
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_LAND, 63'd6, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_TAKEOFF, 63'd7, 12'd9));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_LAND, 63'd8, 12'd7));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_ESTOP, 63'd9, 12'd0));
    send_tick(tick_of(1'b0, 1'b1, 1'b0, ACT_TOGGLE, 63'd10, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd11, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_TOGGLE, 63'd1000, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd999 + 63'(TIMEOUT_RESET), 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd1000 + 63'(TIMEOUT_RESET), 12'd0));
    send_tick(tick_of(1'b0, 1'b1, 1'b0, ACT_TOGGLE, 63'd5000000, 12'd0));
  endtask

  task automatic test_timeout_limits();
    pause_until_drained();
    write_reg(CFG_TIMEOUT, 24'd0);
    // zero timeout trips on the toggle tick itself
    send_tick(tick_of(1'b0, 1'b1, 1'b1, ACT_TOGGLE, 63'd100, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd101, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_TOGGLE, 63'd50, 12'd0));
    pause_until_drained();
    write_reg(CFG_TIMEOUT, 24'hFFFFFF);
    send_tick(tick_of(1'b0, 1'b1, 1'b0, ACT_TOGGLE, 63'd60, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd70, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, ACT_TOGGLE, 63'd200, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd200 + 63'hFFFFFE, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, ACT_TOGGLE, 63'd200 + 63'hFFFFFF, 12'd0));
  endtask

  // One flight from motors stopped: optionally engage, spin up, then a random ending.
  task automatic fly_once();
    item_t t;
    int n;
    int k;
    int top;
    send_tick(make_tick(1'b0, 1'b0, ACT_TOGGLE));
    if ($urandom_range(3) != 0) begin
      send_tick(make_tick(1'b0, 1'b1, ACT_TOGGLE));
      n = $urandom_range(0, 3);
      repeat (n) send_tick(make_tick(1'b0, 1'b0, ACT_TOGGLE));
    end
    send_tick(make_tick(1'b1, 1'b0, ACT_TOGGLE));
    case ($urandom_range(9))
      0: begin
        send_tick(make_tick(1'b1, 1'b1, ACT_TOGGLE));
        n = $urandom_range(1, 8);
        repeat (n) send_tick(make_tick(1'b1, 1'b0, ACT_TOGGLE));
      end
      1: begin
        send_tick(make_tick(1'b1, 1'b1, ACT_ESTOP));
        n = $urandom_range(20, 160);
        repeat (n) send_tick(make_tick(1'b1, $urandom_range(9) == 0, 3'($urandom)));
      end
      default: begin
        send_tick(make_tick(1'b1, 1'b1, ACT_TAKEOFF));
        n = $urandom_range(1, 25);
        repeat (n) send_tick(make_tick(1'b1, $urandom_range(9) == 0, 3'($urandom)));
        if ($urandom_range(4) != 0) begin
          // keep the ramp start within a couple of periods of reaching zero
          top = 2 * reg_land_step;
          if (top > 4095) top = 4095;
          t = make_tick(1'b1, 1'b1, ACT_LAND);
          t.serial_enabled = 1'b1;
          t.ctrl_thrust = ($urandom_range(7) == 0) ? 12'($urandom) :
                          12'($urandom_range(0, top));
          send_tick(t);
          k = 0;
          while (sv_mode == MODE_LANDING && k < LAND_TICK_CAP) begin
            send_tick(make_tick(1'b1, $urandom_range(49) == 0, 3'($urandom)));
            k++;
          end
        end
      end
    endcase
  endtask

  task automatic test_random_flights();
    item_t t;
    int phase;
    int budget;
    for (phase = 0; phase < PHASES; phase++) begin
      pause_until_drained();
      case (phase)
        0: begin
          write_reg(CFG_AXIS_ENABLE, 24'd0);
          write_reg(CFG_TIMEOUT, 24'd1);
          write_reg(CFG_LAND_STEP, 24'd4095);
        end
        1: begin
          write_reg(CFG_AXIS_ENABLE, 24'd15);
          write_reg(CFG_TIMEOUT, 24'hFFFFFF);
          write_reg(CFG_LAND_STEP, 24'd0);
        end
        default: begin
          write_reg(CFG_AXIS_ENABLE, 24'($urandom_range(0, 15)));
          write_reg(CFG_TIMEOUT, ($urandom_range(1) == 0) ? 24'($urandom_range(1, 5000)) :
                                 24'($urandom_range(1, 24'hFFFFFF)));
          write_reg(CFG_LAND_STEP, 24'($urandom_range(1, 300)));
        end
      endcase
      clock_us = 63'({$urandom, $urandom});
      steady = (phase == 2);
      budget = ticks_sent + RANDOM_TICKS / PHASES;
      while (ticks_sent < budget) begin
        if ($urandom_range(99) < 15) begin
          t = make_tick(1'($urandom), 1'($urandom), 3'($urandom));
          t.serial_enabled = 1'($urandom);
          send_tick(t);
        end else begin
          fly_once();
        end
        if ($urandom_range(19) == 0) pause_until_drained();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    tick_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_AXIS_ENABLE;
    cfg_wdata = 24'd0;
    sv_mode = MODE_OFF;
    sv_motors_prev = 1'b0;
    sv_toggle_start = '0;
    sv_tick = 32'd0;
    sv_land_thrust = 12'd0;
    sv_beeper = 1'b0;
    reg_axis_enable = 4'd0;
    reg_timeout = TIMEOUT_RESET;
    reg_land_step = LAND_STEP_RESET;
    clock_us = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_modes();
    test_timeout_limits();
    test_random_flights();

    pause_until_drained();
    repeat (10) @(posedge clk);
    $display("%0d ticks sent, %0d results checked, %0d register writes",
             ticks_sent, results_checked, reg_writes);
    $display("%0d landings ramped down to idle, %0d entries into error, %0d mismatches",
             landings_done, error_entries, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- rotor_flight_mode_supervisor.f -----
+incdir+rtl
rtl/rfms_pkg.sv
rtl/rfms_step.sv
rtl/rotor_flight_mode_supervisor.sv
rtl/rfms_checker.sv
test/rotor_flight_mode_supervisor_test.sv
